[design/quoted_word_tokenizer_defines.svh]
// Assertion macros for the quoted word tokenizer.
// Used by the top level; expects signals named clk and rst_n in scope.
`ifndef QUOTED_WORD_TOKENIZER_DEFINES_SVH
`define QUOTED_WORD_TOKENIZER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QWT_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tokenizer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define QWT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tokenizer assertion failed");

// The expression must never be true out of reset.
`define QWT_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("tokenizer assertion failed");

`endif

[design/qwt_pkg.sv]
// Package for the quoted word tokenizer: beat types, character codes, quote modes,
// input and result kinds, and queue sizing. Depends on nothing.
package qwt_pkg;

  typedef struct packed {
    logic       kind;
    logic [7:0] ch;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] out_char;
    logic       last;
  } out_beat_t;

  localparam logic [7:0] CH_BLANK  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam logic [1:0] MODE_PLAIN  = 2'd0;
  localparam logic [1:0] MODE_SINGLE = 2'd1;
  localparam logic [1:0] MODE_DOUBLE = 2'd2;

  localparam logic IN_CHAR = 1'b0;
  localparam logic IN_LEND = 1'b1;

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_WEND = 2'd1;
  localparam logic [1:0] KIND_LEND = 2'd2;

  localparam int unsigned QWT_DEPTH = 4;
  localparam int unsigned QWT_PTR_W = $clog2(QWT_DEPTH);
  localparam int unsigned QWT_CNT_W = $clog2(QWT_DEPTH + 1);

endpackage

[design/quoted_word_tokenizer.sv]
// Top level of the quoted word tokenizer: quoting state, per-character
// decode and a four-entry result queue. Depends on qwt_pkg and the defines header.
//
//   Channel | Direction | Beat
//   in_     | input     | qwt_pkg::in_beat_t  (kind, ch)
//   out_    | output    | qwt_pkg::out_beat_t (out_kind, out_char, last)
//
// One input beat is decoded in the cycle it is accepted, yielding up to two results.
// The queue sets the rate: one input per cycle while two entries are free, and one
// result leaves per cycle when out_stall is low, so sustained rate is one per cycle.
// Reset empties the queue and returns the tokenizer to unquoted, outside any word.
// in_stall rises when fewer than two entries are free; out_stall holds the head result.
`include "quoted_word_tokenizer_defines.svh"

module quoted_word_tokenizer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  qwt_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output qwt_pkg::out_beat_t  out_data
);
  import qwt_pkg::*;

  logic [1:0]           quote_mode_r, quote_mode_nxt;
  logic                 in_word_r, in_word_nxt;
  logic                 pesc_r, pesc_nxt;
  logic                 desc_r, desc_nxt;

  out_beat_t            queue_r [QWT_DEPTH];
  logic [QWT_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QWT_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QWT_CNT_W-1:0] count_r, count_nxt;

  logic                 in_fire;
  logic                 out_fire;
  logic [1:0]           nres;
  out_beat_t            res0;
  out_beat_t            res1;
  logic [7:0]           c;

  function automatic out_beat_t mk(input logic [1:0] k, input logic [7:0] ch,
                                   input logic lst);
    out_beat_t b;
    b.out_kind = k;
    b.out_char = (k == KIND_CHAR) ? ch : 8'h00;
    b.last     = lst;
    return b;
  endfunction

  assign in_stall  = count_r > QWT_CNT_W'(QWT_DEPTH - 2);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = count_r != '0;
  assign out_fire  = out_valid && !out_stall;
  assign out_data  = queue_r[rd_ptr_r];
  assign c         = in_data.ch;

  always_comb begin
    quote_mode_nxt = quote_mode_r;
    in_word_nxt    = in_word_r;
    pesc_nxt       = pesc_r;
    desc_nxt       = desc_r;
    nres           = 2'd0;
    res0           = mk(KIND_CHAR, c, 1'b1);
    res1           = mk(KIND_CHAR, c, 1'b1);
    priority if (in_data.kind == IN_LEND) begin
      if (in_word_r) begin
        res0 = mk(KIND_WEND, 8'h00, 1'b0);
        res1 = mk(KIND_LEND, 8'h00, 1'b1);
        nres = 2'd2;
      end else begin
        res0 = mk(KIND_LEND, 8'h00, 1'b1);
        nres = 2'd1;
      end
      quote_mode_nxt = MODE_PLAIN;
      in_word_nxt    = 1'b0;
      pesc_nxt       = 1'b0;
      desc_nxt       = 1'b0;
    end else if (pesc_r) begin
      pesc_nxt    = 1'b0;
      in_word_nxt = 1'b1;
      nres        = 2'd1;
    end else if (desc_r) begin
      desc_nxt = 1'b0;
      if (c != CH_BSLASH && c != CH_DQUOTE) begin
        res0 = mk(KIND_CHAR, CH_BSLASH, 1'b0);
        nres = 2'd2;
      end else begin
        nres = 2'd1;
      end
    end else if (quote_mode_r == MODE_SINGLE) begin
      if (c == CH_SQUOTE) begin
        quote_mode_nxt = MODE_PLAIN;
      end else begin
        nres = 2'd1;
      end
    end else if (quote_mode_r == MODE_DOUBLE) begin
      if (c == CH_DQUOTE) begin
        quote_mode_nxt = MODE_PLAIN;
      end else if (c == CH_BSLASH) begin
        desc_nxt = 1'b1;
      end else begin
        nres = 2'd1;
      end
    end else begin
      quote_mode_nxt = MODE_PLAIN;
      if (c == CH_BLANK || c == CH_TAB) begin
        if (in_word_r) begin
          res0        = mk(KIND_WEND, 8'h00, 1'b1);
          nres        = 2'd1;
          in_word_nxt = 1'b0;
        end
      end else if (c == CH_SQUOTE) begin
        quote_mode_nxt = MODE_SINGLE;
        in_word_nxt    = 1'b1;
      end else if (c == CH_DQUOTE) begin
        quote_mode_nxt = MODE_DOUBLE;
        in_word_nxt    = 1'b1;
      end else if (c == CH_BSLASH) begin
        pesc_nxt = 1'b1;
      end else begin
        in_word_nxt = 1'b1;
        nres        = 2'd1;
      end
    end
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (in_fire) begin
      wr_ptr_nxt = wr_ptr_r + QWT_PTR_W'(nres);
    end
    if (out_fire) begin
      rd_ptr_nxt = rd_ptr_r + QWT_PTR_W'(1);
    end
    count_nxt = count_r + (in_fire ? QWT_CNT_W'(nres) : '0) - QWT_CNT_W'(out_fire);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quote_mode_r <= MODE_PLAIN;
      in_word_r    <= 1'b0;
      pesc_r       <= 1'b0;
      desc_r       <= 1'b0;
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      count_r      <= '0;
    end else begin
      if (in_fire) begin
        quote_mode_r <= quote_mode_nxt;
        in_word_r    <= in_word_nxt;
        pesc_r       <= pesc_nxt;
        desc_r       <= desc_nxt;
      end
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && nres != 2'd0) begin
      queue_r[wr_ptr_r] <= res0;
    end
    if (in_fire && nres == 2'd2) begin
      queue_r[wr_ptr_r + QWT_PTR_W'(1)] <= res1;
    end
  end

  `QWT_ASSERT_NEVER(a_count_bound, count_r > QWT_CNT_W'(QWT_DEPTH))
  `QWT_ASSERT_NEVER(a_one_escape, pesc_r && desc_r)
  `QWT_ASSERT_NEXT(a_eol_clears, in_fire && in_data.kind == IN_LEND,
                   quote_mode_r == MODE_PLAIN && !in_word_r && !pesc_r && !desc_r)
  `QWT_ASSERT_IMPLY(a_ptr_count, count_r == '0, wr_ptr_r == rd_ptr_r)

endmodule
